[hdl/iut_pkg.sv]
// ----------------------------------------------------------------------------
// iut_pkg: shared widths for the interval union table
// Timestamp and stream word widths used by the table, the comparator and
// the top level.
// ----------------------------------------------------------------------------
package iut_pkg;

  localparam int TS_W      = 64;
  localparam int IN_W      = 128;
  localparam int OUT_W     = 264;
  localparam int COUNT_W   = 5;

endpackage

[hdl/interval_union_table_unit.sv]
// ----------------------------------------------------------------------------
// interval_union_table_unit: sorted table of disjoint intervals
// Inserts each interval in start order and re-merges touching intervals.
// ----------------------------------------------------------------------------
//   The input stream carries one interval per word (start, inclusive end).
//   The output stream returns one word per input: the merged interval that
//   holds the input, its start minus the lowest start seen, the lowest
//   start, the stored interval count and an overflow flag.
//   An input word is taken only while the sequencer is idle. For each
//   stored interval the sequencer spends a read/compare step and a merge
//   step through the shared comparator and the single read port, with one
//   more merge step when the new interval lands inside the table. The next
//   word is taken only once the sequencer is back in idle after its output
//   step, so words are handled one at a time.
//   The merge writes the spare bank and the banks swap only when it
//   completes with room, so a refused insert leaves the table as it was.
//   Reset empties the table, sets the lowest start to all ones and drops
//   any pending output word. A receiver stall holds the sequencer at its
//   last step only while an earlier output word still waits.
// ----------------------------------------------------------------------------
module interval_union_table_unit
  import iut_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // s_tdata fields from bit 0: span_start[63:0], span_end[127:64]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // m_tdata fields from bit 0: group_start[63:0], group_end[127:64],
  // group_offset[191:128], lowest_start[255:192], span_count[260:256],
  // overflow[261], zero fill[263:262]
  output logic [OUT_W-1:0] m_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam int CW = $clog2(DEPTH + 2);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD   = 7'b0000010,
    ST_CHK  = 7'b0000100,
    ST_FEED = 7'b0001000,
    ST_TAIL = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t          state;
  logic [TS_W-1:0] span_s;
  logic [TS_W-1:0] span_e;
  logic [TS_W-1:0] low;
  logic [NW-1:0]   total;
  logic            bank;
  logic [NW-1:0]   idx;
  logic [CW-1:0]   cnt;
  logic [TS_W-1:0] cur_s;
  logic [TS_W-1:0] cur_e;
  logic [TS_W-1:0] grp_s;
  logic [TS_W-1:0] grp_e;
  logic            tgt;
  logic            placed;
  logic            ins;
  logic            s_lower;
  logic            ovf;

  // Comparator and memory hookup.
  logic [TS_W-1:0] a0, b0, a1, b1;
  logic            lt0, eq0, lt1;
  logic            rd_en, wr_en;
  logic [AW:0]     rd_addr, wr_addr;
  logic [TS_W-1:0] rd_s, rd_e;

  // Feed step helpers.
  logic            feed_en;
  logic            x_new;
  logic [TS_W-1:0] xs, xe;
  logic            newent;
  logic            room;
  logic [NW-1:0]   nxt;
  logic [CW-1:0]   cnt_m1;
  logic            more;

  // Output word helpers.
  logic [TS_W:0]         diff;
  logic [TS_W-1:0]       offset;
  logic [NW+COUNT_W-1:0] total_wide;

  iut_cmp u_cmp (
    .a0  (a0),
    .b0  (b0),
    .a1  (a1),
    .b1  (b1),
    .lt0 (lt0),
    .eq0 (eq0),
    .lt1 (lt1)
  );

  iut_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_start (cur_s),
    .wr_end   (cur_e),
    .rd_start (rd_s),
    .rd_end   (rd_e)
  );

  assign s_tready = (state == ST_IDLE);

  // The item fed to the merge is either the new interval or the entry read.
  assign feed_en = (state == ST_FEED) || ((state == ST_TAIL) && !placed);
  assign x_new   = (state == ST_FEED) ? ins : 1'b1;
  assign xs      = x_new ? span_s : rd_s;
  assign xe      = x_new ? span_e : rd_e;
  assign newent  = (cnt == '0) || lt0;
  assign room    = (cnt <= CW'(DEPTH));
  assign nxt     = idx + NW'(1);
  assign more    = (nxt < total);
  assign cnt_m1  = cnt - CW'(1);

  // Operand steering for the shared comparator.
  always_comb begin
    a0 = cur_e;
    b0 = xs;
    a1 = cur_e;
    b1 = xe;
    case (state)
      ST_IDLE: begin
        a0 = s_tdata[TS_W-1:0];
        b0 = low;
        a1 = s_tdata[IN_W-1:TS_W];
        b1 = s_tdata[TS_W-1:0];
      end
      ST_CHK: begin
        a0 = span_s;
        b0 = rd_s;
        a1 = span_e;
        b1 = rd_e;
      end
      default: begin
        a0 = cur_e;
        b0 = xs;
        a1 = cur_e;
        b1 = xe;
      end
    endcase
  end

  // Read from the live bank, write merged entries to the spare bank.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {bank, {AW{1'b0}}};
    if (state == ST_RD) begin
      rd_en = (total != '0);
    end else if ((state == ST_FEED) && !ins && more) begin
      rd_en   = 1'b1;
      rd_addr = {bank, nxt[AW-1:0]};
    end
    wr_en   = (feed_en && newent && room && (cnt != '0)) || ((state == ST_FIN) && room);
    wr_addr = {~bank, cnt_m1[AW-1:0]};
  end

  // Output word fields.
  assign diff       = {1'b0, grp_s} - {1'b0, low};
  assign offset     = diff[TS_W] ? '0 : diff[TS_W-1:0];
  assign total_wide = {{COUNT_W{1'b0}}, total};

  // Sequencer and merge datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      total    <= '0;
      low      <= '1;
      bank     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Output valid rises when a word is loaded and falls when it is taken.
      if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Merge step shared by the table walk and the tail insert.
      if (feed_en) begin
        if (newent) begin
          if (room) begin
            if ((cnt != '0) && tgt) begin
              grp_s <= cur_s;
              grp_e <= cur_e;
            end
            cur_s <= xs;
            cur_e <= xe;
            cnt   <= cnt + CW'(1);
            tgt   <= x_new;
          end
        end else begin
          if (lt1) begin
            cur_e <= xe;
          end
          if (x_new) begin
            tgt <= 1'b1;
          end
        end
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            span_s  <= s_tdata[TS_W-1:0];
            span_e  <= lt1 ? s_tdata[TS_W-1:0] : s_tdata[IN_W-1:TS_W];
            grp_s   <= s_tdata[TS_W-1:0];
            grp_e   <= s_tdata[IN_W-1:TS_W];
            s_lower <= lt0;
            idx     <= '0;
            cnt     <= '0;
            tgt     <= 1'b0;
            placed  <= 1'b0;
            ins     <= 1'b0;
            state   <= ST_RD;
          end
        end
        ST_RD: begin
          state <= (total != '0) ? ST_CHK : ST_TAIL;
        end
        ST_CHK: begin
          ins   <= !placed && (lt0 || (eq0 && lt1));
          state <= ST_FEED;
        end
        ST_FEED: begin
          if (ins) begin
            ins    <= 1'b0;
            placed <= 1'b1;
          end else begin
            idx   <= nxt;
            state <= more ? ST_CHK : ST_TAIL;
          end
        end
        ST_TAIL: begin
          placed <= 1'b1;
          state  <= ST_FIN;
        end
        ST_FIN: begin
          ovf <= !room;
          if (room) begin
            bank  <= ~bank;
            total <= cnt[NW-1:0];
            if (tgt) begin
              grp_s <= cur_s;
              grp_e <= cur_e;
            end
            if (s_lower) begin
              low <= span_s;
            end
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register load; payload needs no reset.
  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata[63:0]    <= ovf ? '0 : grp_s;
      m_tdata[127:64]  <= ovf ? '0 : grp_e;
      m_tdata[191:128] <= ovf ? '0 : offset;
      m_tdata[255:192] <= low;
      m_tdata[260:256] <= total_wide[COUNT_W-1:0];
      m_tdata[261]     <= ovf;
      m_tdata[263:262] <= 2'b00;
    end
  end

endmodule

[hdl/iut_cmp.sv]
// ----------------------------------------------------------------------------
// iut_cmp: shared two-lane timestamp comparator
// Lane 0 gives less-than and equal, lane 1 gives less-than. The sequencer
// steers the operands of both lanes in every state.
// ----------------------------------------------------------------------------
module iut_cmp
  import iut_pkg::*;
(
  input  logic [TS_W-1:0] a0,
  input  logic [TS_W-1:0] b0,
  input  logic [TS_W-1:0] a1,
  input  logic [TS_W-1:0] b1,
  output logic            lt0,
  output logic            eq0,
  output logic            lt1
);

  // Unsigned compares, one per lane.
  assign lt0 = a0 < b0;
  assign eq0 = a0 == b0;
  assign lt1 = a1 < b1;

endmodule

[hdl/iut_mem.sv]
// ----------------------------------------------------------------------------
// iut_mem: double-banked interval store
// Holds two copies of the table; the merge reads one bank and writes the
// other. One registered read port and one write port.
// ----------------------------------------------------------------------------
module iut_mem
  import iut_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH):0]     rd_addr,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH):0]     wr_addr,
  input  logic [TS_W-1:0]            wr_start,
  input  logic [TS_W-1:0]            wr_end,
  output logic [TS_W-1:0]            rd_start,
  output logic [TS_W-1:0]            rd_end
);

  localparam int Entries = 2 ** ($clog2(DEPTH) + 1);

  logic [TS_W-1:0] starts [Entries];
  logic [TS_W-1:0] ends   [Entries];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      starts[wr_addr] <= wr_start;
      ends[wr_addr]   <= wr_end;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_start <= starts[rd_addr];
      rd_end   <= ends[rd_addr];
    end
  end

endmodule

[dv/interval_union_checker.sv]
// ----------------------------------------------------------------------------
// interval_union_checker: scoreboard for the interval union table
// Watches both stream channels of the table. Every accepted input word is run
// through a local model of the sorted interval table, and the predicted
// output word is queued. Every accepted output word is compared field by
// field with the oldest prediction. Mismatches and stray words are counted.
// ----------------------------------------------------------------------------
module interval_union_checker
  import iut_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  // s_tdata fields from bit 0: span_start[63:0], span_end[127:64]
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  // m_tdata fields from bit 0: group_start, group_end, group_offset,
  // lowest_start, span_count, overflow, zero fill
  input  logic [OUT_W-1:0] m_tdata,
  output int               errors,
  output int               pending
);

  // Output word layout, declared from the top bit down.
  typedef struct packed {
    logic [1:0]         fill;
    logic               ovf;
    logic [COUNT_W-1:0] count;
    logic [TS_W-1:0]    low_start;
    logic [TS_W-1:0]    grp_offset;
    logic [TS_W-1:0]    grp_end;
    logic [TS_W-1:0]    grp_start;
  } group_word_t;

  // Local copy of the stored table.
  logic [TS_W-1:0] tab_start [DEPTH];
  logic [TS_W-1:0] tab_end   [DEPTH];
  int              tab_n;
  logic [TS_W-1:0] low_seen;

  // Scratch table built during one merge pass; one spare slot for overflow.
  logic [TS_W-1:0] work_start [DEPTH+1];
  logic [TS_W-1:0] work_end   [DEPTH+1];
  int              work_n;

  group_word_t     group_q [$];

  // Append an interval to the scratch table, joining it with the last one
  // when that one reaches at least its start.
  function void merge_in(input logic [TS_W-1:0] s, input logic [TS_W-1:0] e);
    if (work_n == 0 || work_end[work_n-1] < s) begin
      if (work_n < DEPTH + 1) begin
        work_start[work_n] = s;
        work_end[work_n]   = e;
        work_n++;
      end
    end else if (e > work_end[work_n-1]) begin
      work_end[work_n-1] = e;
    end
  endfunction

  // Insert one interval and work out the output word it causes.
  task automatic predict_insert(input logic [TS_W-1:0] s, input logic [TS_W-1:0] e_raw,
                                output group_word_t r);
    logic [TS_W-1:0] e;
    logic [TS_W-1:0] gs;
    logic [TS_W-1:0] ge;
    int              n;
    bit              placed;
    // An end below the start is raised to the start.
    e      = (e_raw < s) ? s : e_raw;
    n      = (tab_n > DEPTH) ? DEPTH : tab_n;
    placed = 0;
    work_n = 0;
    gs     = '0;
    ge     = '0;
    r      = '0;
    for (int i = 0; i < n; i++) begin
      if (!placed && (s < tab_start[i] || (s == tab_start[i] && e < tab_end[i]))) begin
        merge_in(s, e);
        placed = 1;
      end
      merge_in(tab_start[i], tab_end[i]);
    end
    if (!placed) merge_in(s, e);

    if (work_n > DEPTH) begin
      // Refused: table and lowest start stay as they were.
      r.ovf       = 1'b1;
      r.low_start = low_seen;
      r.count     = n[COUNT_W-1:0];
    end else begin
      for (int i = 0; i < work_n; i++) begin
        tab_start[i] = work_start[i];
        tab_end[i]   = work_end[i];
        if (work_start[i] <= s && work_end[i] >= e) begin
          gs = work_start[i];
          ge = work_end[i];
        end
      end
      tab_n = work_n;
      if (work_start[0] < low_seen) low_seen = work_start[0];
      r.grp_start  = gs;
      r.grp_end    = ge;
      r.grp_offset = (gs > low_seen) ? gs - low_seen : '0;
      r.low_start  = low_seen;
      r.count      = work_n[COUNT_W-1:0];
    end
  endtask

  function automatic bit field_ok(input string name, input logic [TS_W-1:0] want,
                                  input logic [TS_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 0;
    end
    return 1;
  endfunction

  // Track both channels; pop before queueing so a word never meets its own input.
  always @(posedge clk) begin : track
    group_word_t want;
    group_word_t got;
    group_word_t fresh;
    bit          ok;
    if (rst) begin
      tab_n    = 0;
      low_seen = '1;
      group_q.delete();
      errors   = 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (group_q.size() == 0) begin
          $display("%0t: output word with no prediction waiting, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = group_q.pop_front();
          ok = 1;
          ok = field_ok("group_start", want.grp_start, got.grp_start) && ok;
          ok = field_ok("group_end", want.grp_end, got.grp_end) && ok;
          ok = field_ok("group_offset", want.grp_offset, got.grp_offset) && ok;
          ok = field_ok("lowest_start", want.low_start, got.low_start) && ok;
          ok = field_ok("span_count", TS_W'(want.count), TS_W'(got.count)) && ok;
          ok = field_ok("overflow", TS_W'(want.ovf), TS_W'(got.ovf)) && ok;
          ok = field_ok("zero fill", TS_W'(want.fill), TS_W'(got.fill)) && ok;
          if (!ok) errors++;
        end
      end
      if (s_tvalid && s_tready) begin
        predict_insert(s_tdata[TS_W-1:0], s_tdata[2*TS_W-1:TS_W], fresh);
        group_q = {group_q, fresh};
      end
      pending <= group_q.size();
    end
  end

endmodule

[dv/tb_interval_union_table_unit.sv]
// ----------------------------------------------------------------------------
// tb_interval_union_table_unit: stream test of the interval union table
// Drives intervals into the table: a directed opening over extreme values,
// reversed ends, touching and adjacent intervals and a full table, then
// random episodes that each fill a fresh timestamp region and usually close
// it with a bridging interval, then a closing group at timestamp zero. Both
// stream sides stall at random. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_interval_union_table_unit;
  import iut_pkg::*;

  localparam int              DEPTH        = 16;
  localparam int              NUM_EPISODES = 44;
  localparam int              IDLE_LIMIT   = 2000;
  localparam int              FLUSH_CYCLES = 60;
  localparam logic [TS_W-1:0] TS_MAX       = '1;
  localparam logic [TS_W-1:0] ANCHOR       = 64'h1000;
  localparam logic [TS_W-1:0] STRIDE       = 64'h05A0_0000_0000_0000;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  // s_tdata fields from bit 0: span_start[63:0], span_end[127:64]
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  // m_tdata fields from bit 0: group_start, group_end, group_offset,
  // lowest_start, span_count, overflow, zero fill
  logic [OUT_W-1:0] m_tdata;
  int               errors;
  int               pending;
  int               idle_cycles;
  int               ready_left;
  logic             calm;

  interval_union_table_unit #(.DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  interval_union_checker #(.DEPTH(DEPTH)) u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TS_W-1:0] rand_ts();
    return {$urandom, $urandom};
  endfunction

  // Receiver side: bursts of ready broken by random stalls.
  always @(posedge clk) begin : ready_gen
    int gap;
    if (rst) begin
      m_tready   <= 1'b0;
      ready_left <= 0;
    end else if (calm) begin
      m_tready   <= 1'b1;
      ready_left <= 0;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (m_tready) begin
      gap = pick_gap();
      if (gap > 0) begin
        m_tready   <= 1'b0;
        ready_left <= gap - 1;
      end else begin
        ready_left <= $urandom_range(0, 7);
      end
    end else begin
      m_tready   <= 1'b1;
      ready_left <= $urandom_range(0, 7);
    end
  end

  // Watchdog over stretches with no word moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one interval and hold it until the table takes the word.
  task automatic send_span(input logic [TS_W-1:0] s, input logic [TS_W-1:0] e);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {e, s};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending until every predicted word has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One random episode inside a fresh region above the earlier ones.
  task automatic run_episode(input int ep);
    logic [TS_W-1:0] base;
    logic [TS_W-1:0] width;
    logic [TS_W-1:0] s;
    logic [TS_W-1:0] e;
    logic [TS_W-1:0] last_end;
    int              count;
    int              r;
    base     = 64'h10000 + ep * STRIDE + {$urandom_range(0, (1 << 21) - 1), $urandom};
    width    = 64'd1 << $urandom_range(6, 24);
    last_end = base;
    count    = $urandom_range(16, 34);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      s = base + (rand_ts() & (width - 1));
      e = s + (rand_ts() & ((width >> 3) - 1));
      if (r < 45) begin
        // Short interval anywhere in the region.
      end else if (r < 60) begin
        // Starts right on the last end, so it touches.
        s = last_end;
        e = s + (rand_ts() & ((width >> 3) - 1));
      end else if (r < 70) begin
        // Starts one past the last end, so it does not touch.
        s = last_end + 1;
        e = s + (rand_ts() & ((width >> 3) - 1));
      end else if (r < 78) begin
        e = s - 1 - (rand_ts() & (width - 1));
      end else if (r < 86) begin
        e = s;
      end else if (r < 96) begin
        s = base + (rand_ts() & ((width >> 2) - 1));
        e = s + (rand_ts() & (width - 1));
      end else begin
        // Stray interval anywhere in the timestamp range.
        s = rand_ts();
        e = (r[0]) ? rand_ts() : s + $urandom_range(0, 255);
      end
      send_span(s, e);
      last_end = (e < s) ? s : e;
    end
    // Usually fold everything up to the region end into one interval.
    if ($urandom_range(0, 99) < 85) send_span(ANCHOR, base + width + $urandom_range(0, 3));
  endtask

  initial begin
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    calm        <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed opening.
    send_span(64'h2000, 64'h20FF);
    send_span(ANCHOR, 64'h10FF);             // new lowest start
    send_span(64'h3000, 64'h2000);           // end below start
    send_span(64'h2100, 64'h2180);           // adjacent, not touching
    send_span(64'h2180, 64'h2200);           // touches previous end
    send_span(64'h2000, 64'h2010);           // same start, shorter end
    send_span(64'h2000, 64'h2300);           // same start, swallows neighbor
    send_span(64'h1100, 64'h1FFF);
    send_span(TS_MAX, TS_MAX);
    send_span(TS_MAX - 1, 64'h0);            // end below start at the top
    send_span(TS_MAX - 1, TS_MAX);
    send_span(64'h3000, 64'h3000);           // duplicate of a point interval
    // Fill the table until inserts are refused.
    for (int k = 0; k < 13; k++) send_span(64'h4000 + k * 64'h100, 64'h4010 + k * 64'h100);
    send_span(64'h4000, 64'h4005);           // contained, accepted while full
    send_span(64'h8000, 64'h8000);           // refused while full
    send_span(ANCHOR, 64'h5000);             // collapse the low end
    drain();

    // Random episodes.
    for (int ep = 1; ep <= NUM_EPISODES; ep++) begin
      calm <= ($urandom_range(0, 3) == 0);
      run_episode(ep);
      if (ep == 5 || $urandom_range(0, 7) == 0) drain();
    end
    calm <= 1'b0;

    // Closing group down at timestamp zero.
    send_span(64'h0, 64'h0);
    send_span(64'h1, TS_MAX);
    send_span(64'h0, 64'hFFFF);
    send_span(64'h5, 64'h3);

    drain();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
